>>> hw/rtl/lmss_pkg.sv
package lmss_pkg;

   // panel geometry
   localparam int WIDTH      = 64;
   localparam int HEIGHT     = 64;
   localparam int HALF_ROWS  = HEIGHT / 2;
   localparam int STORE_SIZE = WIDTH * HEIGHT;
   localparam int COL_W      = $clog2(WIDTH);
   localparam int ROW_W      = $clog2(HEIGHT);
   localparam int PAIR_W     = $clog2(HALF_ROWS);
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   localparam logic [15:0] RESET_ON_TICKS = 16'd120;

   // operation codes
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_WRITE    = 3'd1,
      OP_CLEAR    = 3'd2,
      OP_COL_DOWN = 3'd3,
      OP_COL_UP   = 3'd4,
      OP_ROW_DOWN = 3'd5,
      OP_ROW_UP   = 3'd6,
      OP_SPARE    = 3'd7
   } op_type;

   // scan phases
   typedef enum logic [2:0] {
      PH_SHIFT = 3'b001,
      PH_LATCH = 3'b010,
      PH_LIT   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] pixel_x;
      logic [5:0] pixel_y;
      logic [2:0] pixel_color;
   } req_word_type;

   typedef struct packed {
      logic [2:0] upper_color;
      logic [2:0] lower_color;
      logic       shift_pulse;
      logic [4:0] row_address;
      logic       latch_pulse;
      logic       output_enable_n;
      logic       frame_end;
   } rsp_word_type;

   // requests from the scan control to the frame store
   typedef struct packed {
      logic              clear_start;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [2:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_upper;
      logic [ADDR_W-1:0] rd_addr_lower;
   } store_ctl_type;

   // column add with wrap around the panel width
   function automatic logic [COL_W-1:0] col_add(logic [COL_W-1:0] a, logic [COL_W-1:0] b);
      logic [COL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (COL_W+1)'(WIDTH)) s = s - (COL_W+1)'(WIDTH);
      return s[COL_W-1:0];
   endfunction

   // row add with wrap around the panel height
   function automatic logic [ROW_W-1:0] row_add(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
      logic [ROW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ROW_W+1)'(HEIGHT)) s = s - (ROW_W+1)'(HEIGHT);
      return s[ROW_W-1:0];
   endfunction

endpackage

>>> hw/rtl/lmss_frame_store.sv
module lmss_frame_store (
   input  logic                   clock,
   input  logic                   reset,
   input  lmss_pkg::store_ctl_type ctl,
   output logic                   busy,
   output logic [2:0]             rd_upper,
   output logic [2:0]             rd_lower
);
   import lmss_pkg::*;

   logic [2:0]        mem [STORE_SIZE];
   logic              clearing_ff;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [2:0]        rd_upper_ff;
   logic [2:0]        rd_lower_ff;

   // clearing sweep, one word a cycle, after reset and on a clear request
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clear_addr_ff == ADDR_W'(STORE_SIZE - 1)) clearing_ff <= 1'b0;
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end else if (ctl.clear_start) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end
   end

   // single write port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // two registered read ports, held between reads
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_upper_ff <= mem[ctl.rd_addr_upper];
         rd_lower_ff <= mem[ctl.rd_addr_lower];
      end
   end

   assign busy     = clearing_ff;
   assign rd_upper = rd_upper_ff;
   assign rd_lower = rd_lower_ff;

endmodule

>>> hw/rtl/led_matrix_scan_with_scroll.sv
// Scan tick path: the store read and stage-one register, then the output register; rsp_stall
// can hold a result between them. Throughput: one word per cycle for ticks, pixel writes and
// rotations while req_stall is low; rotations only move the row and column offsets that
// map panel coordinates onto the frame store.
// A clear holds req_stall high while the frame store is swept one word a cycle.
// Reset is synchronous; after reset the same clearing sweep runs before the first word is taken.
// Scan state, offsets and on_ticks (120) reset at once.
module led_matrix_scan_with_scroll (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lmss_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lmss_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);
   import lmss_pkg::*;

   // scan and mapping state
   phase_type         phase_ff, phase_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAIR_W-1:0] pair_ff, pair_in;
   logic [15:0]       lit_ff, lit_in;
   logic [COL_W-1:0]  col_ofs_ff, col_ofs_in;
   logic [ROW_W-1:0]  row_ofs_ff, row_ofs_in;
   logic [15:0]       on_ticks_ff;

   // pipeline
   logic              s1_valid_ff;
   rsp_word_type      s1_word_ff, s1_word_in;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   store_ctl_type     store_ctl;
   logic              store_busy;
   logic [2:0]        rd_upper;
   logic [2:0]        rd_lower;

   logic              req_accept;
   logic              tick_accept;
   logic              out_advance;
   logic [15:0]       limit;
   logic [15:0]       lit_inc;
   logic [COL_W-1:0]  scan_col_phys;
   logic [ROW_W-1:0]  upper_row_phys;
   logic [ROW_W-1:0]  lower_row_phys;
   logic [COL_W-1:0]  wr_col_phys;
   logic [ROW_W-1:0]  wr_row_phys;
   logic              pixel_in_range;

   // handshakes
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = store_busy || (s1_valid_ff && !out_advance);
   assign req_accept  = req_valid && !req_stall;
   assign tick_accept = req_accept && (req_data.op == OP_TICK);
   assign csr_ready   = 1'b1;

   // on_ticks register
   always_ff @(posedge clock) begin
      if (reset) begin
         on_ticks_ff <= RESET_ON_TICKS;
      end else if (csr_valid) begin
         on_ticks_ff <= csr_data;
      end
   end

   // next scan state and tick result control
   assign limit   = (on_ticks_ff == 16'd0) ? 16'd1 : on_ticks_ff;
   assign lit_inc = lit_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      col_in     = col_ff;
      pair_in    = pair_ff;
      lit_in     = lit_ff;
      s1_word_in = '0;
      s1_word_in.row_address     = 5'(pair_ff);
      s1_word_in.output_enable_n = 1'b1;
      case (phase_ff)
         PH_LATCH: begin
            s1_word_in.latch_pulse = 1'b1;
            phase_in = PH_LIT;
            lit_in   = '0;
         end
         PH_LIT: begin
            s1_word_in.output_enable_n = 1'b0;
            lit_in = lit_inc;
            if (lit_inc >= limit || lit_inc == 16'd0) begin
               s1_word_in.frame_end = (pair_ff == PAIR_W'(HALF_ROWS - 1));
               lit_in   = '0;
               col_in   = '0;
               phase_in = PH_SHIFT;
               pair_in  = (pair_ff == PAIR_W'(HALF_ROWS - 1)) ? '0 : pair_ff + 1'b1;
            end
         end
         default: begin
            s1_word_in.shift_pulse = 1'b1;
            if (col_ff == COL_W'(WIDTH - 1)) begin
               col_in   = '0;
               phase_in = PH_LATCH;
            end else begin
               col_in   = col_ff + 1'b1;
               phase_in = PH_SHIFT;
            end
         end
      endcase
   end

   // rotation offsets
   always_comb begin
      col_ofs_in = col_ofs_ff;
      row_ofs_in = row_ofs_ff;
      case (req_data.op)
         OP_COL_DOWN: col_ofs_in = col_add(col_ofs_ff, COL_W'(1));
         OP_COL_UP:   col_ofs_in = col_add(col_ofs_ff, COL_W'(WIDTH - 1));
         OP_ROW_DOWN: row_ofs_in = row_add(row_ofs_ff, ROW_W'(1));
         OP_ROW_UP:   row_ofs_in = row_add(row_ofs_ff, ROW_W'(HEIGHT - 1));
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SHIFT;
         col_ff     <= '0;
         pair_ff    <= '0;
         lit_ff     <= '0;
         col_ofs_ff <= '0;
         row_ofs_ff <= '0;
      end else if (req_accept) begin
         if (tick_accept) begin
            phase_ff <= phase_in;
            col_ff   <= col_in;
            pair_ff  <= pair_in;
            lit_ff   <= lit_in;
         end
         col_ofs_ff <= col_ofs_in;
         row_ofs_ff <= row_ofs_in;
      end
   end

   // panel to store address mapping
   assign scan_col_phys  = col_add(col_ff, col_ofs_ff);
   assign upper_row_phys = row_add(ROW_W'(pair_ff), row_ofs_ff);
   assign lower_row_phys = row_add(row_add(ROW_W'(pair_ff), ROW_W'(HALF_ROWS)), row_ofs_ff);
   assign pixel_in_range = (int'(req_data.pixel_x) < WIDTH) && (int'(req_data.pixel_y) < HEIGHT);
   assign wr_col_phys    = col_add(COL_W'(req_data.pixel_x), col_ofs_ff);
   assign wr_row_phys    = row_add(ROW_W'(req_data.pixel_y), row_ofs_ff);

   always_comb begin
      store_ctl.clear_start   = req_accept && (req_data.op == OP_CLEAR);
      store_ctl.wr_en         = req_accept && (req_data.op == OP_WRITE) && pixel_in_range;
      store_ctl.wr_addr       = ADDR_W'(wr_row_phys) * ADDR_W'(WIDTH) + ADDR_W'(wr_col_phys);
      store_ctl.wr_data       = req_data.pixel_color;
      store_ctl.rd_en         = tick_accept;
      store_ctl.rd_addr_upper = ADDR_W'(upper_row_phys) * ADDR_W'(WIDTH) + ADDR_W'(scan_col_phys);
      store_ctl.rd_addr_lower = ADDR_W'(lower_row_phys) * ADDR_W'(WIDTH) + ADDR_W'(scan_col_phys);
   end

   lmss_frame_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .busy     (store_busy),
      .rd_upper (rd_upper),
      .rd_lower (rd_lower)
   );

   // stage one: control fields wait for the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (tick_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_word_ff <= s1_word_in;
      end
   end

   // output word: colors only on shift ticks
   always_comb begin
      rsp_data_in = s1_word_ff;
      if (s1_word_ff.shift_pulse) begin
         rsp_data_in.upper_color = rd_upper;
         rsp_data_in.lower_color = rd_lower;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> bench/led_matrix_scan_with_scroll_tb.sv
`timescale 1ns / 100ps

module led_matrix_scan_with_scroll_tb;
   import lmss_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int PLAN_ROWS   = 20;
   localparam int HOLD_CYCLES = 300;

   // one row of the directed table
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } plan_row_type;

   // results that can be read straight off the panel state
   localparam rsp_word_type BLANK_SHIFT = rsp_word_type'({3'd0, 3'd0, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0});
   localparam rsp_word_type COL1_SHIFT  = rsp_word_type'({3'd7, 3'd5, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0});

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [15:0]  csr_data;

   // panel image and scan state as the block should hold them
   logic [2:0]        pix [HEIGHT][WIDTH];
   logic [COL_W-1:0]  scan_col;
   logic [4:0]        pair_q;
   phase_type         phase_q;
   logic [15:0]       lit_count;
   logic [15:0]       on_ticks_q;

   rsp_word_type pending_scan [$];
   plan_row_type plan [PLAN_ROWS];

   int  mismatches      = 0;
   int  results_checked = 0;
   int  words_sent      = 0;
   int  clears_sent     = 0;
   int  rotations_sent  = 0;
   int  frame_ends      = 0;
   int  cycle_count     = 0;
   int  hold_asks       = 0;
   int  hold_served     = 0;
   bit  gaps_on         = 1'b1;

   led_matrix_scan_with_scroll dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                  pending_scan.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // one scan tick of the panel: advances the scan and returns its outputs
   function automatic rsp_word_type scan_step();
      rsp_word_type r;
      logic [15:0]  limit;
      limit = (on_ticks_q == 16'd0) ? 16'd1 : on_ticks_q;
      r = '0;
      r.row_address = pair_q;
      r.output_enable_n = 1'b1;
      case (phase_q)
         PH_LATCH: begin
            r.latch_pulse = 1'b1;
            phase_q = PH_LIT;
            lit_count = '0;
         end
         PH_LIT: begin
            r.output_enable_n = 1'b0;
            lit_count = lit_count + 16'd1;
            if (lit_count >= limit || lit_count == 16'd0) begin
               if (int'(pair_q) == HALF_ROWS - 1) r.frame_end = 1'b1;
               lit_count = '0;
               scan_col = '0;
               phase_q = PH_SHIFT;
               pair_q = (int'(pair_q) == HALF_ROWS - 1) ? 5'd0 : pair_q + 5'd1;
            end
         end
         default: begin
            r.upper_color = pix[pair_q][scan_col];
            r.lower_color = pix[int'(pair_q) + HALF_ROWS][scan_col];
            r.shift_pulse = 1'b1;
            if (int'(scan_col) == WIDTH - 1) begin
               scan_col = '0;
               phase_q = PH_LATCH;
            end else begin
               scan_col = scan_col + 1'b1;
               phase_q = PH_SHIFT;
            end
         end
      endcase
      return r;
   endfunction

   // move the whole image one column or one row, with wrap
   task automatic rotate_image(op_type op);
      logic [2:0] snap [HEIGHT][WIDTH];
      snap = pix;
      for (int r = 0; r < HEIGHT; r++) begin
         for (int c = 0; c < WIDTH; c++) begin
            case (op)
               OP_COL_DOWN: pix[r][c] = snap[r][(c + 1) % WIDTH];
               OP_COL_UP:   pix[r][c] = snap[r][(c + WIDTH - 1) % WIDTH];
               OP_ROW_DOWN: pix[r][c] = snap[(r + 1) % HEIGHT][c];
               default:     pix[r][c] = snap[(r + HEIGHT - 1) % HEIGHT][c];
            endcase
         end
      end
   endtask

   // update the panel for one accepted word, queue the scan result if any
   task automatic apply_word(req_word_type w, logic typed, rsp_word_type want);
      rsp_word_type r;
      words_sent++;
      case (w.op)
         OP_TICK: begin
            r = scan_step();
            if (r.frame_end) frame_ends++;
            pending_scan.push_back(typed ? want : r);
         end
         OP_WRITE: begin
            if (int'(w.pixel_x) < WIDTH && int'(w.pixel_y) < HEIGHT)
               pix[w.pixel_y][w.pixel_x] = w.pixel_color;
         end
         OP_CLEAR: begin
            clears_sent++;
            foreach (pix[yy, xx]) pix[yy][xx] = 3'd0;
         end
         OP_COL_DOWN, OP_COL_UP, OP_ROW_DOWN, OP_ROW_UP: begin
            rotations_sent++;
            rotate_image(op_type'(w.op));
         end
         default: ;
      endcase
   endtask

   // offer one word and hold it until taken
   task automatic send_word(req_word_type w, logic typed, rsp_word_type want);
      @(negedge clock);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 15) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      apply_word(w, typed, want);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_scan.size() != 0) @(posedge clock);
   endtask

   // lit time is only changed with the block quiet
   task automatic write_on_ticks(logic [15:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      on_ticks_q = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      pick = $urandom_range(0, 199);
      w.pixel_x = 6'($urandom_range(0, 63));
      w.pixel_y = 6'($urandom_range(0, 63));
      w.pixel_color = 3'($urandom_range(0, 7));
      if (pick < 150)      w.op = OP_TICK;
      else if (pick < 184) w.op = OP_WRITE;
      else if (pick < 186) w.op = OP_CLEAR;
      else if (pick < 188) w.op = OP_SPARE;
      else begin
         case ((pick - 188) / 3)
            0:       w.op = OP_COL_DOWN;
            1:       w.op = OP_COL_UP;
            2:       w.op = OP_ROW_DOWN;
            default: w.op = OP_ROW_UP;
         endcase
      end
      return w;
   endfunction

   function automatic req_word_type make_word(op_type op, int x, int y, int c);
      req_word_type w;
      w.op = op;
      w.pixel_x = 6'(x);
      w.pixel_y = 6'(y);
      w.pixel_color = 3'(c);
      return w;
   endfunction

   function automatic plan_row_type row(op_type op, int x, int y, int c, logic typed,
                                        rsp_word_type want);
      plan_row_type p;
      p.word.op = op;
      p.word.pixel_x = 6'(x);
      p.word.pixel_y = 6'(y);
      p.word.pixel_color = 3'(c);
      p.typed = typed;
      p.want = want;
      return p;
   endfunction

   task automatic random_words(int count);
      for (int i = 0; i < count; i++) send_word(random_word(), 1'b0, '0);
   endtask

   // compare the scan result against the oldest expectation
   task automatic check_field(string name, int expv, int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : score_check
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_scan.size() == 0) begin
            $error("scan result with nothing expected: %h", rsp_data);
            mismatches++;
         end else begin
            want = pending_scan.pop_front();
            results_checked++;
            check_field("upper_color", want.upper_color, rsp_data.upper_color);
            check_field("lower_color", want.lower_color, rsp_data.lower_color);
            check_field("shift_pulse", want.shift_pulse, rsp_data.shift_pulse);
            check_field("row_address", want.row_address, rsp_data.row_address);
            check_field("latch_pulse", want.latch_pulse, rsp_data.latch_pulse);
            check_field("output_enable_n", want.output_enable_n, rsp_data.output_enable_n);
            check_field("frame_end", want.frame_end, rsp_data.frame_end);
         end
      end
   end

   // result side: random stall, long hold-off on request
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(0, 99) < 15);
         end
      end
   end

   // main sequence
   initial begin : stimulus
      int start_frames;
      int sweep_words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      foreach (pix[r, c]) pix[r][c] = 3'd0;
      scan_col = '0;
      pair_q = '0;
      phase_q = PH_SHIFT;
      lit_count = '0;
      on_ticks_q = RESET_ON_TICKS;

      plan[0]  = row(OP_TICK,      0,  0, 0, 1'b1, BLANK_SHIFT);
      plan[1]  = row(OP_WRITE,     1,  0, 7, 1'b0, '0);
      plan[2]  = row(OP_WRITE,     1, 32, 5, 1'b0, '0);
      plan[3]  = row(OP_TICK,      0,  0, 0, 1'b1, COL1_SHIFT);
      plan[4]  = row(OP_WRITE,    63, 63, 7, 1'b0, '0);
      plan[5]  = row(OP_WRITE,    63, 31, 6, 1'b0, '0);
      plan[6]  = row(OP_WRITE,     2,  0, 3, 1'b0, '0);
      plan[7]  = row(OP_COL_DOWN,  0,  0, 0, 1'b0, '0);
      plan[8]  = row(OP_TICK,      0,  0, 0, 1'b0, '0);
      plan[9]  = row(OP_COL_UP,   63, 63, 7, 1'b0, '0);
      plan[10] = row(OP_ROW_DOWN,  0,  0, 0, 1'b0, '0);
      plan[11] = row(OP_ROW_UP,   63, 63, 7, 1'b0, '0);
      plan[12] = row(OP_TICK,     63, 63, 7, 1'b0, '0);
      plan[13] = row(OP_SPARE,    63, 63, 7, 1'b0, '0);
      plan[14] = row(OP_WRITE,     4, 32, 1, 1'b0, '0);
      plan[15] = row(OP_TICK,      0,  0, 0, 1'b0, '0);
      plan[16] = row(OP_CLEAR,     0,  0, 0, 1'b0, '0);
      plan[17] = row(OP_TICK,      0,  0, 0, 1'b1, BLANK_SHIFT);
      plan[18] = row(OP_WRITE,     6,  0, 4, 1'b0, '0);
      plan[19] = row(OP_TICK,      0,  0, 0, 1'b0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset lit time
      for (int i = 0; i < PLAN_ROWS; i++) send_word(plan[i].word, plan[i].typed, plan[i].want);

      // short lit time, with a long result hold-off partway through
      write_on_ticks(16'd3);
      random_words(150);
      hold_asks++;
      random_words(250);

      // shortest lit time, no idling on either side, one full drain in the middle
      write_on_ticks(16'd1);
      gaps_on = 1'b0;
      random_words(175);
      wait_drained();
      random_words(175);
      gaps_on = 1'b1;

      // longest lit time: the scan parks on one lit row pair
      write_on_ticks(16'hFFFF);
      random_words(200);

      // lit time lowered while a pair is lit
      write_on_ticks(16'd40000);
      while (!(phase_q == PH_LIT && lit_count >= 16'd20))
         send_word(make_word(OP_TICK, 0, 0, 0), 1'b0, '0);
      write_on_ticks(16'd5);
      random_words(200);

      // zero lit time, ticks with a few pixel writes until a frame ends or the budget runs out
      write_on_ticks(16'd0);
      start_frames = frame_ends;
      sweep_words = 0;
      while (frame_ends == start_frames && sweep_words < 150) begin
         if ($urandom_range(0, 9) == 0)
            send_word(make_word(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 7)), 1'b0, '0);
         else
            send_word(make_word(OP_TICK, 0, 0, 0), 1'b0, '0);
         sweep_words++;
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("sent %0d words (%0d clears, %0d rotations) over seven lit-time settings",
               words_sent, clears_sent, rotations_sent);
      $display("checked %0d scan results, %0d frame ends among them", results_checked,
               frame_ends);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/lmss_pkg.sv
hw/rtl/lmss_frame_store.sv
hw/rtl/led_matrix_scan_with_scroll.sv
bench/led_matrix_scan_with_scroll_tb.sv
